// ===== sv/gcl_pkg.sv =====
// Package for the graphics coordinate loader: widths, codes, request and result
// types, and small helper functions. Depends on nothing; every other file imports it.
package gcl_pkg;

    // Number of vertex slots and the widths that follow from it.
    localparam int VERTEX_SLOTS = 4;
    localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
    localparam int COUNT_W      = $clog2(VERTEX_SLOTS + 1);

    // Slots shown on the result channel.
    localparam int OUT_VERTS = 4;

    localparam int COORD_W    = 32;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_Y = 1'b1;

    // Axis selector codes.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_XY   = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Primitive kind codes.
    localparam logic [2:0] KIND_POINT    = 3'd0;
    localparam logic [2:0] KIND_LINE     = 3'd1;
    localparam logic [2:0] KIND_TRIANGLE = 3'd2;
    localparam logic [2:0] KIND_QUAD     = 3'd3;
    localparam logic [2:0] KIND_RECT     = 3'd4;

    // One coordinate-load request.
    typedef struct packed {
        logic                 relative_mode;
        logic [1:0]           axis_select;
        logic [2:0]           primitive_kind;
        logic [COORD_W-1:0]   data_word;
    } t_item;

    // One drawn primitive.
    typedef struct packed {
        logic [2:0]                         drawn_kind;
        logic [OUT_VERTS-1:0][COORD_W-1:0]  vx;
        logic [OUT_VERTS-1:0][COORD_W-1:0]  vy;
    } t_result;

    // Status of the vertex core, seen by the top level.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               pending_fire;
        logic               advance;
    } t_core_status;

    // Sign extension of a 16-bit half to a full coordinate.
    function automatic logic [COORD_W-1:0] sext16(input logic [HALF_W-1:0] v);
        return {{(COORD_W - HALF_W){v[HALF_W-1]}}, v};
    endfunction

    // Vertices a primitive needs before it fires.
    function automatic logic [COUNT_W-1:0] need_count(input logic [2:0] kind);
        logic [COUNT_W-1:0] n;
        case (kind)
            KIND_POINT:    n = COUNT_W'(0);
            KIND_LINE:     n = COUNT_W'(2);
            KIND_TRIANGLE: n = COUNT_W'(3);
            KIND_QUAD:     n = COUNT_W'(4);
            KIND_RECT:     n = COUNT_W'(2);
            default:       n = COUNT_W'(0);
        endcase
        return n;
    endfunction

endpackage

// ===== sv/gcl_in_if.sv =====
// Request channel of the coordinate loader: valid/ready and the request fields.
// Depends on gcl_pkg for widths.
interface gcl_in_if;
    import gcl_pkg::*;

    logic               valid;
    logic               ready;
    logic               relative_mode;
    logic [1:0]         axis_select;
    logic [2:0]         primitive_kind;
    logic [COORD_W-1:0] data_word;

    modport source (output valid, relative_mode, axis_select, primitive_kind, data_word,
                    input ready);
    modport sink   (input valid, relative_mode, axis_select, primitive_kind, data_word,
                    output ready);
endinterface

// ===== sv/gcl_out_if.sv =====
// Result channel of the coordinate loader: valid/ready, primitive kind and four vertices.
// Depends on gcl_pkg for widths.
interface gcl_out_if;
    import gcl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [2:0]                drawn_kind;
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
    logic signed [COORD_W-1:0] vertex3_x;
    logic signed [COORD_W-1:0] vertex3_y;

    modport source (output valid, drawn_kind, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                           vertex2_x, vertex2_y, vertex3_x, vertex3_y,
                    input ready);
    modport sink   (input valid, drawn_kind, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                          vertex2_x, vertex2_y, vertex3_x, vertex3_y,
                    output ready);
endinterface

// ===== sv/gcl_vertex_core.sv =====
// Vertex core: input register, window offset registers, vertex slots and the
// primitive test. Depends on gcl_pkg and gcl_in_if.
module gcl_vertex_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gcl_in_if.sink                        i_in,
    input  logic                          i_cfg_we,
    input  logic [gcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_out_free,
    output gcl_pkg::t_result              o_res,
    output logic                          o_res_valid,
    output gcl_pkg::t_core_status         o_status
);
    import gcl_pkg::*;

    logic                   r_in_valid;
    t_item                  r_in;
    logic [HALF_W-1:0]      r_win_x;
    logic [HALF_W-1:0]      r_win_y;
    logic [COORD_W-1:0]     r_vx [VERTEX_SLOTS];
    logic [COORD_W-1:0]     r_vy [VERTEX_SLOTS];
    logic [COUNT_W-1:0]     r_count;
    logic [SLOT_W-1:0]      r_last;

    logic [COORD_W-1:0]     n_vx [VERTEX_SLOTS];
    logic [COORD_W-1:0]     n_vy [VERTEX_SLOTS];
    logic [COUNT_W-1:0]     n_count;
    logic [SLOT_W-1:0]      n_last;

    logic                   can_load;
    logic [SLOT_W-1:0]      slot;
    logic [COORD_W-1:0]     ref_x;
    logic [COORD_W-1:0]     ref_y;
    logic [COORD_W-1:0]     off_x;
    logic [COORD_W-1:0]     off_y;
    logic [COORD_W-1:0]     add_x;
    logic [COORD_W-1:0]     add_y;
    logic [COUNT_W-1:0]     count_after;
    logic                   fire;
    logic                   advance;

    // The held request moves on unless it fires while the result register is full and not being emptied.
    assign advance    = r_in_valid && (!fire || i_out_free);
    assign i_in.ready = !r_in_valid || advance;

    // Coordinate arithmetic against the slot state left by the previous request.
    assign can_load = (r_count < COUNT_W'(VERTEX_SLOTS));
    assign slot     = r_count[SLOT_W-1:0];
    assign ref_x    = r_in.relative_mode ? r_vx[r_last] : sext16(r_win_x);
    assign ref_y    = r_in.relative_mode ? r_vy[r_last] : sext16(r_win_y);
    assign off_x    = (r_in.axis_select == AXIS_XY) ?
                      sext16(r_in.data_word[COORD_W-1:HALF_W]) : r_in.data_word;
    assign off_y    = (r_in.axis_select == AXIS_XY) ?
                      sext16(r_in.data_word[HALF_W-1:0]) : r_in.data_word;
    assign add_x    = off_x + ref_x;
    assign add_y    = off_y + ref_y;

    // Slot write and count update.
    always_comb begin
        n_vx = r_vx;
        n_vy = r_vy;
        if (can_load) begin
            case (r_in.axis_select)
                AXIS_X:  n_vx[slot] = add_x;
                AXIS_Y:  n_vy[slot] = add_y;
                AXIS_XY: begin
                    n_vx[slot] = add_x;
                    n_vy[slot] = add_y;
                end
                default: ;
            endcase
        end
        count_after = can_load ? r_count + COUNT_W'(1) : r_count;
        n_last      = can_load ? slot : r_last;
        fire        = (r_in.primitive_kind <= KIND_RECT) &&
                      (count_after >= need_count(r_in.primitive_kind));
        n_count     = fire ? COUNT_W'(0) : count_after;
    end

    // Result shows the first four slots after this request's write.
    always_comb begin
        o_res.drawn_kind = r_in.primitive_kind;
        for (int k = 0; k < OUT_VERTS; k++) begin
            o_res.vx[k] = n_vx[k];
            o_res.vy[k] = n_vy[k];
        end
    end
    assign o_res_valid = r_in_valid && fire;

    assign o_status.count        = r_count;
    assign o_status.pending_fire = r_in_valid && fire;
    assign o_status.advance      = advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in.relative_mode  <= i_in.relative_mode;
            r_in.axis_select    <= i_in.axis_select;
            r_in.primitive_kind <= i_in.primitive_kind;
            r_in.data_word      <= i_in.data_word;
        end
    end

    // Window offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x <= '0;
            r_win_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIN_X: r_win_x <= i_cfg_wdata;
                CFG_WIN_Y: r_win_y <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Vertex slots, count and last loaded slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VERTEX_SLOTS; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_count <= '0;
            r_last  <= '0;
        end else if (advance) begin
            r_vx    <= n_vx;
            r_vy    <= n_vy;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

endmodule

// ===== sv/gcl_out_reg.sv =====
// Result register of the coordinate loader, driving the result channel.
// Depends on gcl_pkg and gcl_out_if.
module gcl_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gcl_pkg::t_result i_res,
    input  logic             i_res_valid,
    output logic             o_free,
    gcl_out_if.source        o_out
);
    import gcl_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register can take a new result when empty or when its request leaves now.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    // Drive the channel fields.
    assign o_out.valid      = r_valid;
    assign o_out.drawn_kind = r_res.drawn_kind;
    assign o_out.vertex0_x  = r_res.vx[0];
    assign o_out.vertex0_y  = r_res.vy[0];
    assign o_out.vertex1_x  = r_res.vx[1];
    assign o_out.vertex1_y  = r_res.vy[1];
    assign o_out.vertex2_x  = r_res.vx[2];
    assign o_out.vertex2_y  = r_res.vy[2];
    assign o_out.vertex3_x  = r_res.vx[3];
    assign o_out.vertex3_y  = r_res.vy[3];

endmodule

// ===== sv/graphics_coordinate_loader.sv =====
// Top level of the graphics coordinate loader: vertex core and result register.
// Depends on gcl_pkg, gcl_in_if, gcl_out_if, gcl_vertex_core and gcl_out_reg.

// The loader takes one coordinate-load request per clock while input ready is
// high and returns drawn primitives. Each request passes an input register, a
// single pass of one 32-bit add per axis and the slot update, then a result
// register. Requests that do not fire never wait on the result channel; a
// firing request waits in the input register only while the result register
// still holds a primitive that the sink has not taken, and input ready drops
// for exactly that case. Window offsets are written through the configuration
// port by the user, only while no request is in flight; it is not enforced.
module graphics_coordinate_loader (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gcl_in_if.sink                         i_in,
    gcl_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [gcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gcl_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import gcl_pkg::*;

    t_result      res;
    logic         res_valid;
    logic         out_free;
    t_core_status status;

    gcl_vertex_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_res_valid (res_valid),
        .o_status    (status)
    );

    gcl_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .i_res_valid (res_valid),
        .o_free      (out_free),
        .o_out       (o_out)
    );

    // The slot count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= COUNT_W'(VERTEX_SLOTS))
        else $error("vertex count beyond slot limit");

    // A primitive that fires restarts the count.
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pending_fire && status.advance |=> status.count == '0)
        else $error("count not cleared after a drawn primitive");

    // Input stalls only behind a firing request and a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> status.pending_fire && o_out.valid && !o_out.ready)
        else $error("input stalled without a blocked result");

    // Only drawable kinds reach the result channel.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.drawn_kind <= KIND_RECT)
        else $error("result carries a kind that does not draw");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for graphics_coordinate_loader: directed and random
// coordinate-load requests checked against a vertex-slot predictor.
// Depends on gcl_pkg, gcl_in_if, gcl_out_if and the loader RTL.
module tb_top;
    import gcl_pkg::*;

    // Primitive kinds that load a vertex but never draw.
    localparam logic [2:0] KIND_NODRAW5 = 3'd5;
    localparam logic [2:0] KIND_NODRAW6 = 3'd6;
    localparam logic [2:0] KIND_NODRAW7 = 3'd7;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_PCT     = 37;
    localparam int N_DIRECTED   = 23;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    gcl_in_if  req_ch ();
    gcl_out_if prim_ch ();

    graphics_coordinate_loader u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_ch),
        .o_out       (prim_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor state: window origin, vertex slots and load bookkeeping.
    logic [CFG_DATA_W-1:0] win_x, win_y;
    logic [COORD_W-1:0]    slot_x [VERTEX_SLOTS];
    logic [COORD_W-1:0]    slot_y [VERTEX_SLOTS];
    int                    loaded;
    int                    last_slot;

    t_result expected_prims [$];

    int  errors;
    int  requests_sent;
    int  prims_checked;
    int  settings_used;
    int  cycles;
    bit  no_gaps;
    bit  hold_off_req;

    // Directed requests; the first rows start from the reset state.
    t_item directed_table [N_DIRECTED] = '{
        '{1'b0, AXIS_NONE, KIND_POINT,    32'h0000_0000},
        '{1'b0, AXIS_XY,   KIND_POINT,    32'h7FFF_8000},
        '{1'b1, AXIS_XY,   KIND_POINT,    32'h0001_0001},
        '{1'b0, AXIS_X,    KIND_NODRAW5,  32'h8000_0000},
        '{1'b1, AXIS_Y,    KIND_NODRAW6,  32'hFFFF_FFFF},
        '{1'b0, AXIS_XY,   KIND_LINE,     32'h1234_5678},
        '{1'b1, AXIS_XY,   KIND_TRIANGLE, 32'hFFFF_0001},
        '{1'b0, AXIS_NONE, KIND_TRIANGLE, 32'h0000_0000},
        '{1'b1, AXIS_X,    KIND_TRIANGLE, 32'h7FFF_FFFF},
        '{1'b0, AXIS_Y,    KIND_QUAD,     32'h8000_0000},
        '{1'b1, AXIS_XY,   KIND_QUAD,     32'h8000_8000},
        '{1'b1, AXIS_XY,   KIND_QUAD,     32'h7FFF_7FFF},
        '{1'b0, AXIS_XY,   KIND_QUAD,     32'hFFFF_FFFF},
        '{1'b0, AXIS_X,    KIND_RECT,     32'h0000_0000},
        '{1'b1, AXIS_Y,    KIND_RECT,     32'hFFFF_FFFF},
        '{1'b0, AXIS_XY,   KIND_NODRAW5,  32'h0064_0064},
        '{1'b1, AXIS_XY,   KIND_NODRAW6,  32'h0001_FFFF},
        '{1'b1, AXIS_X,    KIND_NODRAW7,  32'hFFFF_FFFE},
        '{1'b1, AXIS_Y,    KIND_NODRAW7,  32'h0000_0003},
        '{1'b1, AXIS_XY,   KIND_NODRAW7,  32'h5555_AAAA},
        '{1'b0, AXIS_XY,   KIND_LINE,     32'hAAAA_5555},
        '{1'b1, AXIS_NONE, KIND_RECT,     32'h0000_0000},
        '{1'b0, AXIS_X,    KIND_POINT,    32'hFFFF_FFFF}
    };

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Timeout guard.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d primitives still expected",
                     cycles, expected_prims.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] sign_widen(input logic [HALF_W-1:0] h);
        return {{(COORD_W - HALF_W){h[HALF_W-1]}}, h};
    endfunction

    // Vertices a kind needs before it draws; negative for kinds that never draw.
    function automatic int vertices_needed(input logic [2:0] kind);
        case (kind)
            KIND_POINT:    return 0;
            KIND_LINE:     return 2;
            KIND_TRIANGLE: return 3;
            KIND_QUAD:     return 4;
            KIND_RECT:     return 2;
            default:       return -1;
        endcase
    endfunction

    // Rows whose result is obvious from the reset state carry it here.
    function automatic bit typed_outcome(input int row, output t_result want);
        want = '0;
        want.drawn_kind = KIND_POINT;
        case (row)
            0: return 1'b1;
            1: begin
                want.vx[0] = 32'h0000_7FFF;
                want.vy[0] = 32'hFFFF_8000;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Loads the vertex a request names and tells whether a primitive is drawn.
    function automatic bit load_vertex(input t_item r, output t_result prim);
        logic [COORD_W-1:0] base_x, base_y;
        int slot;
        int need;
        prim = '0;
        if (loaded < VERTEX_SLOTS) begin
            slot   = loaded;
            base_x = r.relative_mode ? slot_x[last_slot] : sign_widen(win_x);
            base_y = r.relative_mode ? slot_y[last_slot] : sign_widen(win_y);
            case (r.axis_select)
                AXIS_XY: begin
                    slot_x[slot] = sign_widen(r.data_word[31:16]) + base_x;
                    slot_y[slot] = sign_widen(r.data_word[15:0]) + base_y;
                end
                AXIS_X:  slot_x[slot] = r.data_word + base_x;
                AXIS_Y:  slot_y[slot] = r.data_word + base_y;
                default: ;
            endcase
            last_slot = slot;
            loaded    = slot + 1;
        end
        need = vertices_needed(r.primitive_kind);
        if (need < 0 || loaded < need)
            return 1'b0;
        loaded = 0;
        prim.drawn_kind = r.primitive_kind;
        for (int k = 0; k < OUT_VERTS; k++) begin
            prim.vx[k] = slot_x[k];
            prim.vy[k] = slot_y[k];
        end
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Offers one request, with a random gap first, and records its outcome
    // once it is accepted. Returns at the falling edge after acceptance.
    task automatic send_request(input t_item r, input bit typed, input t_result want);
        int gap;
        t_result prim;
        gap = 0;
        if (!no_gaps)
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.relative_mode  <= r.relative_mode;
        req_ch.axis_select    <= r.axis_select;
        req_ch.primitive_kind <= r.primitive_kind;
        req_ch.data_word      <= r.data_word;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
        if (load_vertex(r, prim))
            expected_prims.push_back(typed ? want : prim);
        @(negedge i_clk);
    endtask

    // Stops offering and lets every request in flight leave the block.
    task automatic drain;
        req_ch.valid <= 1'b0;
        while (expected_prims.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_window(input logic [CFG_DATA_W-1:0] x, input logic [CFG_DATA_W-1:0] y);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIN_X;
        i_cfg_wdata <= x;
        @(negedge i_clk);
        i_cfg_index <= CFG_WIN_Y;
        i_cfg_wdata <= y;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        win_x = x;
        win_y = y;
        settings_used++;
    endtask

    function automatic t_item random_request(input logic [2:0] kind);
        t_item r;
        logic [COORD_W-1:0] corners [7] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                            32'h7FFF_FFFF, 32'h0000_8000, 32'h8000_8000,
                                            32'h7FFF_7FFF};
        r.relative_mode  = 1'($urandom_range(0, 1));
        r.axis_select    = 2'($urandom_range(0, 3));
        r.primitive_kind = kind;
        r.data_word      = ($urandom_range(0, 99) < 20) ? corners[$urandom_range(0, 6)]
                                                        : $urandom;
        return r;
    endfunction

    // Mostly complete primitives: enough non-drawing loads, sometimes past
    // the slot limit, then the drawing kind. The rest is loose noise.
    task automatic random_traffic(input int n_req);
        int sent;
        int loads;
        logic [2:0] target;
        logic [2:0] draw_kinds [5] = '{KIND_POINT, KIND_LINE, KIND_TRIANGLE,
                                       KIND_QUAD, KIND_RECT};
        sent = 0;
        while (sent < n_req) begin
            if ($urandom_range(0, 99) < 75) begin
                target = draw_kinds[$urandom_range(0, 4)];
                loads  = (target == KIND_POINT) ? 0 : vertices_needed(target) - 1;
                if ($urandom_range(0, 99) < 15)
                    loads += $urandom_range(1, 3);
                repeat (loads) begin
                    send_request(random_request(3'($urandom_range(KIND_NODRAW5,
                                                                  KIND_NODRAW7))),
                                 1'b0, '0);
                    sent++;
                end
                send_request(random_request(target), 1'b0, '0);
            end else begin
                send_request(random_request(3'($urandom_range(0, 7))), 1'b0, '0);
            end
            sent++;
        end
    endtask

    // Result-side ready: random stalls, a steady stretch, and one long hold-off.
    initial begin : result_ready
        int hold;
        hold = 0;
        prim_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && hold == 0) begin
                hold = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold > 0) begin
                prim_ch.ready <= 1'b0;
                hold--;
            end else if (no_gaps) begin
                prim_ch.ready <= 1'b1;
            end else begin
                prim_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Result checker: each drawn primitive against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && prim_ch.valid && prim_ch.ready) begin
            got.drawn_kind = prim_ch.drawn_kind;
            got.vx = {prim_ch.vertex3_x, prim_ch.vertex2_x, prim_ch.vertex1_x,
                      prim_ch.vertex0_x};
            got.vy = {prim_ch.vertex3_y, prim_ch.vertex2_y, prim_ch.vertex1_y,
                      prim_ch.vertex0_y};
            if (expected_prims.size() == 0) begin
                report_error($sformatf("Unexpected primitive kind %0d", got.drawn_kind));
            end else begin
                want = expected_prims.pop_front();
                prims_checked++;
                if (got.drawn_kind !== want.drawn_kind)
                    report_error($sformatf("drawn_kind: expected %0d, got %0d",
                                           want.drawn_kind, got.drawn_kind));
                for (int k = 0; k < OUT_VERTS; k++) begin
                    if (got.vx[k] !== want.vx[k])
                        report_error($sformatf("vertex%0d_x: expected %h, got %h",
                                               k, want.vx[k], got.vx[k]));
                    if (got.vy[k] !== want.vy[k])
                        report_error($sformatf("vertex%0d_y: expected %h, got %h",
                                               k, want.vy[k], got.vy[k]));
                end
            end
        end
    end

    // Main sequence: reset, directed table, back-pressure burst, random phases.
    initial begin : stimulus
        t_result want;
        bit typed;
        logic [31:0] offset_settings [5] = '{32'h8000_7FFF, 32'h7FFF_8000,
                                            32'hFFFF_0001, 32'h0000_0000, 32'h0};
        errors = 0;
        requests_sent = 0;
        prims_checked = 0;
        settings_used = 0;
        no_gaps = 1'b0;
        hold_off_req = 1'b0;
        win_x = '0;
        win_y = '0;
        loaded = 0;
        last_slot = 0;
        for (int k = 0; k < VERTEX_SLOTS; k++) begin
            slot_x[k] = '0;
            slot_y[k] = '0;
        end
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WIN_X;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.relative_mode = 1'b0;
        req_ch.axis_select = AXIS_X;
        req_ch.primitive_kind = KIND_POINT;
        req_ch.data_word = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < N_DIRECTED; row++) begin
            typed = typed_outcome(row, want);
            send_request(directed_table[row], typed, want);
        end

        // Hold the result side off while points keep coming, so the block stalls.
        hold_off_req = 1'b1;
        repeat (30)
            send_request(random_request(KIND_POINT), 1'b0, '0);

        offset_settings[4] = $urandom;
        for (int p = 0; p < 5; p++) begin
            drain();
            set_window(offset_settings[p][31:16], offset_settings[p][15:0]);
            no_gaps = (p == 2);
            random_traffic(110);
        end
        no_gaps = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Checked %0d primitives from %0d requests under %0d window settings,",
                 prims_checked, requests_sent, settings_used + 1);
        $display("including a %0d-cycle result hold-off; %0d mismatches.",
                 HOLD_CYCLES, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/gcl_pkg.sv
sv/gcl_in_if.sv
sv/gcl_out_if.sv
sv/gcl_vertex_core.sv
sv/gcl_out_reg.sv
sv/graphics_coordinate_loader.sv
verif/tb_top.sv
